### hdl/csbc_pkg.sv
// Shared types and constants for the cloud spectral band correction block.
package csbc_pkg;

  localparam int COLS       = 7;
  localparam int NUM_THR    = 6;
  localparam int FRAC_BITS  = 14;
  localparam int DIV_BITS   = 38;
  localparam int DIVIDEND_W = 52;
  localparam int BASE_W     = 37;
  localparam int SUM_W      = 40;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CORRECT = 1'b1;

  localparam logic [19:0]       OUT_MAX    = 20'hFFFFF;
  localparam logic [BASE_W-1:0] ROUND_HALF = BASE_W'(1 << (FRAC_BITS - 1));

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_ZERO = 2'd2,
    ST_BAND = 2'd3
  } status_t;

  typedef struct packed {
    logic              bypass;
    logic              neg;
    status_t           status;
    logic [BASE_W-1:0] base;
    logic [19:0]       irr;
  } csbc_tag_t;

endpackage

### hdl/csbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overrange detect.
module csbc_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  csbc_pkg::csbc_tag_t                 in_tag,
  input  logic [csbc_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [15:0]                         divisor,
  output logic                                out_valid,
  output csbc_pkg::csbc_tag_t                 out_tag,
  output logic [csbc_pkg::DIV_BITS-1:0]       quotient,
  output logic                                rem_nz,
  output logic                                big
);
  import csbc_pkg::*;

  localparam int CMP_W = 16 + DIV_BITS;

  logic                v_q   [DIV_BITS+1];
  csbc_tag_t           tag_q [DIV_BITS+1];
  logic [15:0]         dvs_q [DIV_BITS+1];
  logic [15:0]         rem_q [DIV_BITS+1];
  logic [DIV_BITS-1:0] dq_q  [DIV_BITS+1];
  logic                big_q [DIV_BITS+1];

  // entry stage: overrange check and initial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= in_valid;
    end
    tag_q[0] <= in_tag;
    dvs_q[0] <= divisor;
    big_q[0] <= CMP_W'(dividend) >= {divisor, DIV_BITS'(0)};
    rem_q[0] <= 16'(dividend[DIVIDEND_W-1:DIV_BITS]);
    dq_q[0]  <= dividend[DIV_BITS-1:0];
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
    logic [16:0] trial;
    logic        take;

    assign trial = {rem_q[i], dq_q[i][DIV_BITS-1]};
    assign take  = trial >= {1'b0, dvs_q[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
      tag_q[i+1] <= tag_q[i];
      dvs_q[i+1] <= dvs_q[i];
      big_q[i+1] <= big_q[i];
      rem_q[i+1] <= take ? 16'(trial - {1'b0, dvs_q[i]}) : trial[15:0];
      dq_q[i+1]  <= {dq_q[i][DIV_BITS-2:0], take};
    end
  end

  assign out_valid = v_q[DIV_BITS];
  assign out_tag   = tag_q[DIV_BITS];
  assign quotient  = dq_q[DIV_BITS];
  assign rem_nz    = rem_q[DIV_BITS] != 16'd0;
  assign big       = big_q[DIV_BITS];

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> divisor != 16'd0)
    else $error("divisor is zero");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v_q[DIV_BITS] && !big_q[DIV_BITS] |-> rem_q[DIV_BITS] < dvs_q[DIV_BITS])
    else $error("remainder not below divisor");

  a_bypass_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_tag.bypass |-> quotient == '0 && !rem_nz && !big)
    else $error("bypass word carried a nonzero product");

endmodule

### hdl/cloud_spectral_band_correction.sv
// Top level: table load, interval select, interpolation, rounding and saturation.
//
// One word is accepted in every cycle at which start is high; busy is never raised.
// A load word (cmd 0) writes one table coefficient if its row and column are in
// range and gives no result. A correct word (cmd 1) gives one result on
// corrected/status/saturated, marked by done for one cycle. It passes the front
// stages around the table read and multipliers, the restoring divider that forms
// the interpolation quotient (an entry stage and 38 quotient-bit stages), and
// final stages A and B. Results leave in acceptance order. Table entries hold
// no value until loaded; a correct word reading one gives an undefined result.
module cloud_spectral_band_correction #(
  parameter int TABLE_ROWS = 64,
  parameter int FIRST_BAND = 1,
  parameter int LAST_BAND  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [5:0]         table_row,
  input  logic [2:0]         table_column,
  input  logic [15:0]        coefficient,
  input  logic [5:0]         band_index,
  input  logic signed [15:0] clear_index,
  input  logic [19:0]        irradiance,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic [19:0]        corrected,
  output logic [1:0]         status,
  output logic               saturated
);
  import csbc_pkg::*;

  localparam int RW        = $clog2(TABLE_ROWS);
  localparam int AW        = RW + 3;
  localparam int MEM_DEPTH = 2 ** AW;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // thresholds, index 0 is a fixed zero
  logic signed [15:0] thr [7];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 7; i++) begin
        thr[i] <= 16'sd0;
      end
    end else if (cfg_write && cfg_index < 3'(NUM_THR)) begin
      thr[cfg_index + 3'd1] <= cfg_data;
    end
  end

  // stage 1: interval select
  logic [2:0] h_next, l_next;
  logic       none_next;

  always_comb begin
    h_next    = 3'd0;
    l_next    = 3'd0;
    none_next = 1'b0;
    if (clear_index < thr[6]) begin
      h_next = 3'd6;
      l_next = 3'd6;
    end else if (clear_index >= thr[2]) begin
      h_next = 3'd1;
      l_next = 3'd2;
    end else if (clear_index < thr[5]) begin
      h_next = 3'd5;
      l_next = 3'd6;
    end else if (clear_index < thr[4]) begin
      h_next = 3'd4;
      l_next = 3'd5;
    end else if (clear_index < thr[3]) begin
      h_next = 3'd3;
      l_next = 3'd4;
    end else if (clear_index < thr[2]) begin
      h_next = 3'd2;
      l_next = 3'd3;
    end else begin
      none_next = 1'b1;
    end
  end

  logic               v1, cmd1, ld_ok1, band_ok1, none1;
  logic [AW-1:0]      wr_addr1;
  logic [15:0]        coef1;
  logic [RW-1:0]      rd_row1;
  logic [2:0]         h1, l1;
  logic signed [15:0] k1;
  logic [19:0]        irr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    cmd1     <= cmd;
    ld_ok1   <= (int'(table_row) < TABLE_ROWS) && (table_column < 3'(COLS));
    wr_addr1 <= {RW'(table_row), table_column};
    coef1    <= coefficient;
    band_ok1 <= (int'(band_index) >= FIRST_BAND - 1) && (int'(band_index) <= LAST_BAND - 1)
                && (int'(band_index) + 1 < TABLE_ROWS);
    rd_row1  <= RW'({1'b0, band_index} + 7'd1);
    h1       <= h_next;
    l1       <= l_next;
    none1    <= none_next;
    k1       <= clear_index;
    irr1     <= irradiance;
  end

  // stage 2: table access, width and distance
  logic [15:0] table_mem [MEM_DEPTH];
  logic [15:0] ch2, cl2;

  always_ff @(posedge clk) begin
    if (v1 && cmd1 == CMD_LOAD && ld_ok1) begin
      table_mem[wr_addr1] <= coef1;
    end
    ch2 <= table_mem[{rd_row1, h1}];
    cl2 <= table_mem[{rd_row1, l1}];
  end

  logic signed [16:0] w_s, dk_s;
  logic               w_zero;
  status_t            st_next;

  always_comb begin
    w_s    = {thr[h1][15], thr[h1]} - {thr[l1][15], thr[l1]};
    dk_s   = {thr[h1][15], thr[h1]} - {k1[15], k1};
    w_zero = (h1 != l1) && (w_s == 17'sd0);
    if (!band_ok1) begin
      st_next = ST_BAND;
    end else if (none1) begin
      st_next = ST_NONE;
    end else if (w_zero) begin
      st_next = ST_ZERO;
    end else begin
      st_next = ST_OK;
    end
  end

  logic        v2, single2, wneg2, bypass2;
  logic [15:0] wabs2, d2;
  status_t     st2;
  logic [19:0] irr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1 && cmd1 == CMD_CORRECT;
    end
    single2 <= (h1 == l1) || w_zero;
    wneg2   <= w_s[16];
    wabs2   <= w_s[16] ? 16'(-w_s) : w_s[15:0];
    d2      <= dk_s[16] ? 16'(-dk_s) : dk_s[15:0];
    bypass2 <= !band_ok1;
    st2     <= st_next;
    irr2    <= irr1;
  end

  // stage 3: column difference times distance, base product
  logic signed [16:0] diff;
  logic [15:0]        dabs;
  logic [35:0]        base_prod;
  assign diff      = {1'b0, cl2} - {1'b0, ch2};
  assign dabs      = diff[16] ? 16'(-diff) : diff[15:0];
  assign base_prod = irr2 * ch2;

  logic              v3, neg3, bypass3;
  logic [31:0]       m3;
  logic [BASE_W-1:0] base3;
  logic [15:0]       wabs3;
  status_t           st3;
  logic [19:0]       irr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    m3      <= (single2 || bypass2) ? 32'd0 : d2 * dabs;
    neg3    <= diff[16] ^ wneg2;
    base3   <= BASE_W'(base_prod) + ROUND_HALF;
    wabs3   <= single2 ? 16'd1 : wabs2;
    bypass3 <= bypass2;
    st3     <= st2;
    irr3    <= irr2;
  end

  // stage 4: split product with the sample
  logic              v4, neg4, bypass4;
  logic [35:0]       pplo4, pphi4;
  logic [BASE_W-1:0] base4;
  logic [15:0]       wabs4;
  status_t           st4;
  logic [19:0]       irr4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    pplo4   <= irr3 * m3[15:0];
    pphi4   <= irr3 * m3[31:16];
    neg4    <= neg3;
    base4   <= base3;
    wabs4   <= wabs3;
    bypass4 <= bypass3;
    st4     <= st3;
    irr4    <= irr3;
  end

  // stage 5: combine partial products
  logic                  v5;
  logic [DIVIDEND_W-1:0] pabs5;
  logic [15:0]           wabs5;
  csbc_tag_t             tag5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
    pabs5       <= DIVIDEND_W'({pphi4, 16'd0}) + DIVIDEND_W'(pplo4);
    wabs5       <= wabs4;
    tag5.bypass <= bypass4;
    tag5.neg    <= neg4;
    tag5.status <= st4;
    tag5.base   <= base4;
    tag5.irr    <= irr4;
  end

  logic                dv_valid, dv_nz, dv_big;
  csbc_tag_t           dv_tag;
  logic [DIV_BITS-1:0] dv_quot;

  csbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v5),
    .in_tag   (tag5),
    .dividend (pabs5),
    .divisor  (wabs5),
    .out_valid(dv_valid),
    .out_tag  (dv_tag),
    .quotient (dv_quot),
    .rem_nz   (dv_nz),
    .big      (dv_big)
  );

  // final stage A: floor quotient plus base
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    if (dv_tag.neg) begin
      sum_next = SUM_W'(dv_tag.base) - SUM_W'(dv_quot) - SUM_W'(dv_nz);
    end else begin
      sum_next = SUM_W'(dv_tag.base) + SUM_W'(dv_quot);
    end
  end

  logic             vf, bigf;
  logic [SUM_W-1:0] sumf;
  csbc_tag_t        tagf;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else begin
      vf <= dv_valid;
    end
    sumf <= sum_next;
    bigf <= dv_big;
    tagf <= dv_tag;
  end

  // final stage B: scale, saturate or bypass, output word
  logic [SUM_W-FRAC_BITS-1:0] qs;
  logic [19:0]                corr_next;
  logic [1:0]                 st_out;
  logic                       sat_next;

  assign qs = sumf[SUM_W-1:FRAC_BITS];

  always_comb begin
    st_out    = tagf.status;
    sat_next  = 1'b1;
    corr_next = OUT_MAX;
    if (tagf.bypass) begin
      st_out    = ST_BAND;
      sat_next  = 1'b0;
      corr_next = tagf.irr;
    end else if (bigf) begin
      corr_next = tagf.neg ? 20'd0 : OUT_MAX;
    end else if (qs[SUM_W-FRAC_BITS-1]) begin
      corr_next = 20'd0;
    end else if (|qs[SUM_W-FRAC_BITS-2:20]) begin
      corr_next = OUT_MAX;
    end else begin
      sat_next  = 1'b0;
      corr_next = qs[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vf;
    end
    corrected <= corr_next;
    status    <= st_out;
    saturated <= sat_next;
  end

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result word right after reset");

  a_band_no_sat: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_BAND |-> !saturated)
    else $error("band bypass word flagged saturated");

  a_sat_at_rail: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> corrected == 20'd0 || corrected == OUT_MAX)
    else $error("saturated word not at a rail");

endmodule
